[rtl/core/ca_row_pkg.sv]
// shared types and constants for the cellular automaton row step unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ca_row_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    REG_COLOUR_MODE = 2'd0,
    REG_RULE_TWO    = 2'd1,
    REG_RULE_THREE  = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [1:0] above_cell;
    logic       last_in_row;
  } in_word_t;

  typedef struct packed {
    logic [1:0] new_cell;
    logic       end_of_run;
  } out_word_t;

  typedef struct packed {
    logic        colour_mode;
    logic [7:0]  rule_two;
    logic [13:0] rule_three;
  } rule_cfg_t;

  typedef struct packed {
    logic [1:0] push_count;
    logic       pop;
  } fifo_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/ca_row_rule.sv]
// next-cell lookup from a three-cell window, pattern or sum rule
// depends on ca_row_pkg
`timescale 1ns / 1ps
`default_nettype none

module ca_row_rule (
  input  var ca_row_pkg::rule_cfg_t cfg,
  input  wire logic [1:0]           left_cell,
  input  wire logic [1:0]           middle_cell,
  input  wire logic [1:0]           right_cell,
  output logic      [1:0]           new_cell
);

  logic [2:0] pattern;
  logic [1:0] left_lvl;
  logic [1:0] middle_lvl;
  logic [1:0] right_lvl;
  logic [2:0] sum;
  logic [2:0] entry;
  logic [1:0] raw;

  always_comb begin
    pattern    = {left_cell != 2'd0, middle_cell != 2'd0, right_cell != 2'd0};
    // cell value 3 counts as 2
    left_lvl   = (left_cell == 2'd3) ? 2'd2 : left_cell;
    middle_lvl = (middle_cell == 2'd3) ? 2'd2 : middle_cell;
    right_lvl  = (right_cell == 2'd3) ? 2'd2 : right_cell;
    sum        = 3'(left_lvl) + 3'(middle_lvl) + 3'(right_lvl);
    entry      = 3'd6 - sum;
    raw        = cfg.rule_three[{entry, 1'b0} +: 2];
    if (cfg.colour_mode) begin
      new_cell = (raw == 2'd3) ? 2'd2 : raw;
    end else begin
      new_cell = {1'b0, cfg.rule_two[~pattern]};
    end
  end

endmodule

`default_nettype wire

[rtl/core/ca_row_fifo.sv]
// small result queue, up to two words pushed and one popped per cycle
// depends on ca_row_pkg
`timescale 1ns / 1ps
`default_nettype none

module ca_row_fifo #(
  parameter int unsigned DEPTH = ca_row_pkg::FIFO_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  var ca_row_pkg::fifo_ctrl_t ctrl,
  input  var ca_row_pkg::out_word_t  wdata0,
  input  var ca_row_pkg::out_word_t  wdata1,
  output ca_row_pkg::out_word_t      rdata,
  output logic                       not_empty,
  output logic                       room_two
);

  localparam int unsigned PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  ca_row_pkg::out_word_t mem [DEPTH];

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] tail_plus1;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    tail_plus1 = (tail == LAST_PTR) ? '0 : tail + PTR_W'(1);
    head_next  = head;
    if (ctrl.pop) begin
      head_next = (head == LAST_PTR) ? '0 : head + PTR_W'(1);
    end
    unique case (ctrl.push_count)
      2'd0:    tail_next = tail;
      2'd1:    tail_next = tail_plus1;
      default: tail_next = (tail_plus1 == LAST_PTR) ? '0 : tail_plus1 + PTR_W'(1);
    endcase
    count_next = count + CNT_W'(ctrl.push_count) - CNT_W'(ctrl.pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push_count != 2'd0) begin
      mem[tail] <= wdata0;
    end
    if (ctrl.push_count == 2'd2) begin
      mem[tail_plus1] <= wdata1;
    end
  end

  assign rdata     = mem[head];
  assign not_empty = (count != '0);
  assign room_two  = (count <= CNT_W'(DEPTH - 2));

endmodule

`default_nettype wire

[rtl/core/cellular_automaton_row_step_unit.sv]
// Row step unit for an elementary cellular automaton. One cell word is accepted per
// cycle from the previous row, in column order, and the next row's cells come out one
// column behind. A word that ends a row of two or more cells yields two results (the
// last cell and the right edge), so short rows run at the output port's one word per
// cycle while out_stall is low; the input stalls only while the result queue (DEPTH
// words) has fewer than two free slots. Rule registers are written through the cfg port
// by the user only while the unit is idle (not enforced); cfg_ready is always high.
// depends on ca_row_pkg, ca_row_rule, ca_row_fifo
`timescale 1ns / 1ps
`default_nettype none

module cellular_automaton_row_step_unit #(
  parameter int unsigned DEPTH = ca_row_pkg::FIFO_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [13:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  var ca_row_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ca_row_pkg::out_word_t     out_data
);

  ca_row_pkg::rule_cfg_t  cfg;
  ca_row_pkg::in_word_t   item;
  ca_row_pkg::fifo_ctrl_t fctrl;
  ca_row_pkg::out_word_t  word0;
  ca_row_pkg::out_word_t  word1;

  logic       item_valid;
  logic       room_two;
  logic       advance;
  logic [1:0] left_cell;
  logic [1:0] middle_cell;
  logic [1:0] cells_seen;
  logic [1:0] rule_cell;
  logic       have_cell;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (ca_row_pkg::reg_index_t'(cfg_index))
        ca_row_pkg::REG_COLOUR_MODE: cfg.colour_mode <= cfg_data[0];
        ca_row_pkg::REG_RULE_TWO:    cfg.rule_two    <= cfg_data[7:0];
        ca_row_pkg::REG_RULE_THREE:  cfg.rule_three  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  assign advance  = item_valid && room_two;
  assign in_stall = item_valid && !room_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
  end

  ca_row_rule u_rule (
    .cfg         (cfg),
    .left_cell   (left_cell),
    .middle_cell (middle_cell),
    .right_cell  (item.above_cell),
    .new_cell    (rule_cell)
  );

  always_comb begin
    have_cell = (cells_seen != 2'd0);
    // second cell of a row gives the left edge
    word0.new_cell   = (cells_seen == 2'd1) ? 2'd0 : rule_cell;
    word0.end_of_run = !item.last_in_row;
    word1.new_cell   = 2'd0;
    word1.end_of_run = 1'b1;
    fctrl.push_count = 2'd0;
    if (advance) begin
      fctrl.push_count = 2'(have_cell) + 2'(item.last_in_row);
    end
    if (!have_cell) begin
      word0 = word1;
    end
    fctrl.pop = out_valid && !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_cell   <= '0;
      middle_cell <= '0;
      cells_seen  <= '0;
    end else if (advance) begin
      if (item.last_in_row) begin
        left_cell   <= '0;
        middle_cell <= '0;
        cells_seen  <= '0;
      end else begin
        left_cell   <= middle_cell;
        middle_cell <= item.above_cell;
        if (cells_seen != 2'd2) begin
          cells_seen <= cells_seen + 2'd1;
        end
      end
    end
  end

  ca_row_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (fctrl),
    .wdata0    (word0),
    .wdata1    (word1),
    .rdata     (out_data),
    .not_empty (out_valid),
    .room_two  (room_two)
  );

  // row end restarts the window
  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && item.last_in_row) |=> (cells_seen == 2'd0))
    else $error("window not cleared after row end");

  // the second word of a run is already queued behind the first
  a_run_complete: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_data.end_of_run) |=> out_valid)
    else $error("run broken in result queue");

  a_seen_saturates: assert property (@(posedge clk) disable iff (rst)
    cells_seen != 2'd3)
    else $error("cell count overran");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> item_valid && $stable(item))
    else $error("input register changed while stalled");

endmodule

`default_nettype wire

[tb/testbench.sv]
// testbench for cellular_automaton_row_step_unit: directed rows, then random rows under
// random rule settings, checked word by word against a predictor of the next grid row
// depends on ca_row_pkg and the unit itself
`timescale 1ns / 1ps

module testbench;

  localparam int RAND_PHASES  = 6;
  localparam int PHASE_CELLS  = 68;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum {ROW_CELL, ROW_CFG} row_kind_t;

  typedef struct {
    bit                    on;
    int                    n;
    ca_row_pkg::out_word_t e0;
    ca_row_pkg::out_word_t e1;
  } typed_exp_t;

  typedef struct {
    row_kind_t              kind;
    ca_row_pkg::in_word_t   word;
    typed_exp_t             typed;
    ca_row_pkg::reg_index_t idx;
    logic [13:0]            val;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [13:0]           cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  ca_row_pkg::in_word_t  in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  ca_row_pkg::out_word_t out_data;

  cellular_automaton_row_step_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the rule registers and the row window
  logic        mode_q = 1'b0;
  logic [7:0]  rule2_q = '0;
  logic [13:0] rule3_q = '0;
  logic [1:0]  win_left = '0;
  logic [1:0]  win_mid = '0;
  logic [1:0]  cells_in_row = '0;

  ca_row_pkg::out_word_t pending_cells[$];
  typed_exp_t  typed_cur = '{on: 1'b0, n: 0, e0: '0, e1: '0};
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          rx_burst = 0;
  int          mismatches = 0;
  int          words_checked = 0;
  int          cells_sent = 0;
  int          rows_sent = 0;
  int          settings_run = 0;
  int          quiet_cycles = 0;

  function automatic logic [1:0] next_cell_value(logic [1:0] l, logic [1:0] m, logic [1:0] r);
    int         pat;
    int         sum;
    logic [1:0] v;
    if (!mode_q) begin
      pat = (|l) * 4 + (|m) * 2 + (|r);
      return {1'b0, rule2_q[7 - pat]};
    end
    sum = int'(l > 2'd2 ? 2'd2 : l) + int'(m > 2'd2 ? 2'd2 : m) + int'(r > 2'd2 ? 2'd2 : r);
    v = rule3_q[2 * (6 - sum) +: 2];
    return (v == 2'd3) ? 2'd2 : v;
  endfunction

  function automatic void predict_next_cells(input ca_row_pkg::in_word_t w,
                                             output ca_row_pkg::out_word_t r0,
                                             output ca_row_pkg::out_word_t r1,
                                             output int n);
    r0 = '0;
    r1 = '0;
    n = 0;
    if (cells_in_row == 2'd1) begin
      n = 1;
    end else if (cells_in_row == 2'd2) begin
      r0.new_cell = next_cell_value(win_left, win_mid, w.above_cell);
      n = 1;
    end
    if (w.last_in_row) begin
      n++;
      win_left = '0;
      win_mid = '0;
      cells_in_row = '0;
    end else begin
      win_left = win_mid;
      win_mid = w.above_cell;
      if (cells_in_row < 2'd2) cells_in_row++;
    end
    if (n == 1) r0.end_of_run = 1'b1;
    else if (n == 2) r1.end_of_run = 1'b1;
  endfunction

  function automatic void check_cell_word(ca_row_pkg::out_word_t got);
    ca_row_pkg::out_word_t want;
    words_checked++;
    if (pending_cells.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected word: new_cell=%0d end_of_run=%0d", got.new_cell, got.end_of_run);
      mismatches++;
    end else begin
      want = pending_cells.pop_front();
      if (got.new_cell !== want.new_cell || got.end_of_run !== want.end_of_run) begin
        if (mismatches < 10)
          $display("word %0d: expected new_cell=%0d end_of_run=%0d, got new_cell=%0d end_of_run=%0d",
                   words_checked, want.new_cell, want.end_of_run, got.new_cell, got.end_of_run);
        mismatches++;
      end
    end
  endfunction

  always @(posedge clk) begin : monitor
    ca_row_pkg::out_word_t r0;
    ca_row_pkg::out_word_t r1;
    int                    n;
    bit                    moved;
    moved = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        check_cell_word(out_data);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        predict_next_cells(in_data, r0, r1, n);
        if (typed_cur.on) begin
          n = typed_cur.n;
          r0 = typed_cur.e0;
          r1 = typed_cur.e1;
        end
        if (n > 0) pending_cells.push_back(r0);
        if (n > 1) pending_cells.push_back(r1);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) moved = 1'b1;
    end
    if (moved) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("cellular_automaton_row_step_unit test failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_burst > 0) begin
      out_stall <= 1'b1;
      rx_burst--;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      rx_burst = $urandom_range(1, 7) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send_word(ca_row_pkg::in_word_t w, typed_exp_t t);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    typed_cur <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cells_sent++;
    if (w.last_in_row) rows_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(ca_row_pkg::reg_index_t idx, logic [13:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ca_row_pkg::REG_COLOUR_MODE: mode_q = val[0];
      ca_row_pkg::REG_RULE_TWO:    rule2_q = val[7:0];
      ca_row_pkg::REG_RULE_THREE:  rule3_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic stim_row_t cell_row(logic [1:0] c, logic l);
    stim_row_t s;
    s = '{kind: ROW_CELL, word: '{above_cell: c, last_in_row: l},
          typed: '{on: 1'b0, n: 0, e0: '0, e1: '0}, idx: ca_row_pkg::REG_UNUSED, val: '0};
    return s;
  endfunction

  function automatic stim_row_t typed_row(logic [1:0] c, logic l, int n,
                                          ca_row_pkg::out_word_t e0,
                                          ca_row_pkg::out_word_t e1);
    stim_row_t s;
    s = cell_row(c, l);
    s.typed = '{on: 1'b1, n: n, e0: e0, e1: e1};
    return s;
  endfunction

  function automatic stim_row_t cfg_row(ca_row_pkg::reg_index_t idx, logic [13:0] val);
    stim_row_t s;
    s = cell_row(2'd0, 1'b0);
    s.kind = ROW_CFG;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  initial begin : stimulus
    stim_row_t            table_q[$];
    typed_exp_t           no_typed;
    ca_row_pkg::in_word_t w;
    logic [13:0]          mode_val;
    logic [13:0]          two_val;
    logic [13:0]          three_val;
    int                   len;
    int                   sent;
    bit                   paused;

    no_typed = '{on: 1'b0, n: 0, e0: '0, e1: '0};

    // reset rules are all zero, so every cell is 0
    table_q.push_back(typed_row(2'd3, 1'b1, 1, {2'd0, 1'b1}, '0));
    table_q.push_back(typed_row(2'd0, 1'b0, 0, '0, '0));
    table_q.push_back(typed_row(2'd2, 1'b0, 1, {2'd0, 1'b1}, '0));
    table_q.push_back(typed_row(2'd1, 1'b0, 1, {2'd0, 1'b1}, '0));
    table_q.push_back(typed_row(2'd3, 1'b1, 2, {2'd0, 1'b0}, {2'd0, 1'b1}));
    // masked writes and an ignored index: mode 0, rule 0xff
    table_q.push_back(cfg_row(ca_row_pkg::REG_COLOUR_MODE, 14'h3FFE));
    table_q.push_back(cfg_row(ca_row_pkg::REG_RULE_TWO, 14'h3FFF));
    table_q.push_back(cfg_row(ca_row_pkg::REG_UNUSED, 14'h0000));
    table_q.push_back(typed_row(2'd0, 1'b0, 0, '0, '0));
    table_q.push_back(typed_row(2'd0, 1'b0, 1, {2'd0, 1'b1}, '0));
    table_q.push_back(typed_row(2'd0, 1'b0, 1, {2'd1, 1'b1}, '0));
    table_q.push_back(typed_row(2'd0, 1'b1, 2, {2'd1, 1'b0}, {2'd0, 1'b1}));
    table_q.push_back(cfg_row(ca_row_pkg::REG_RULE_TWO, 14'd30));
    table_q.push_back(cell_row(2'd1, 1'b0));
    table_q.push_back(cell_row(2'd2, 1'b0));
    table_q.push_back(cell_row(2'd3, 1'b0));
    table_q.push_back(cell_row(2'd0, 1'b0));
    table_q.push_back(cell_row(2'd0, 1'b0));
    table_q.push_back(cell_row(2'd1, 1'b0));
    table_q.push_back(cell_row(2'd0, 1'b1));
    // three-colour, every entry 3 clamps to 2
    table_q.push_back(cfg_row(ca_row_pkg::REG_COLOUR_MODE, 14'd1));
    table_q.push_back(cfg_row(ca_row_pkg::REG_RULE_THREE, 14'h3FFF));
    table_q.push_back(typed_row(2'd3, 1'b0, 0, '0, '0));
    table_q.push_back(typed_row(2'd3, 1'b0, 1, {2'd0, 1'b1}, '0));
    table_q.push_back(typed_row(2'd3, 1'b1, 2, {2'd2, 1'b0}, {2'd0, 1'b1}));
    table_q.push_back(cfg_row(ca_row_pkg::REG_RULE_THREE, 14'h2D1B));
    table_q.push_back(cell_row(2'd1, 1'b0));
    table_q.push_back(cell_row(2'd2, 1'b0));
    table_q.push_back(cell_row(2'd3, 1'b0));
    table_q.push_back(cell_row(2'd0, 1'b0));
    table_q.push_back(cell_row(2'd2, 1'b1));

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    settings_run = 1;
    foreach (table_q[i]) begin
      if (table_q[i].kind == ROW_CFG) begin
        drain();
        write_reg(table_q[i].idx, table_q[i].val);
        settings_run++;
      end else begin
        send_word(table_q[i].word, table_q[i].typed);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      tx_idle_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      mode_val = 14'($urandom_range(0, 16383));
      mode_val[0] = p[0];
      two_val = 14'($urandom_range(0, 16383));
      three_val = 14'($urandom_range(0, 16383));
      if (p == 0) two_val[7:0] = 8'h00;
      if (p == 2) two_val[7:0] = 8'hFF;
      if (p == 1) three_val = 14'h0000;
      if (p == 3) three_val = 14'h3FFF;
      write_reg(ca_row_pkg::REG_COLOUR_MODE, mode_val);
      write_reg(ca_row_pkg::REG_RULE_TWO, two_val);
      write_reg(ca_row_pkg::REG_RULE_THREE, three_val);
      if ($urandom_range(0, 1) == 1)
        write_reg(ca_row_pkg::REG_UNUSED, 14'($urandom_range(0, 16383)));
      settings_run++;
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_CELLS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
        for (int c = 0; c < len; c++) begin
          w.above_cell = 2'($urandom_range(0, 3));
          w.last_in_row = (c == len - 1);
          send_word(w, no_typed);
        end
        sent += len;
        // hold the sender until the queue of expected cells has emptied
        if (p == 2 && !paused && sent >= PHASE_CELLS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("covered %0d cells in %0d rows under %0d rule settings, both colour modes",
             cells_sent, rows_sent, settings_run);
    $display("checked %0d result words, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("cellular_automaton_row_step_unit test passed");
    end else begin
      $display("cellular_automaton_row_step_unit test failed");
    end
    $finish;
  end

endmodule
